/* rtl/core/acpe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package acpe_pkg;

    localparam int HALF_W     = 16;
    localparam int SEED_W     = 32;
    localparam int INDEX_W    = 5;
    localparam int WEIGHT_W   = 5;
    localparam int STAGE_COUNT_DEFAULT = 24;

    localparam logic [HALF_W-1:0] PAR_COL [HALF_W] = '{
        16'h8faf, 16'h9f5e, 16'hbebc, 16'hfd78,
        16'h755f, 16'he511, 16'h458d, 16'h84b5,
        16'h896a, 16'h92d4, 16'ha5a8, 16'hcb50,
        16'h190f, 16'h321e, 16'h643c, 16'hc7d7
    };

    typedef struct packed {
        logic [HALF_W-1:0]   word;
        logic [WEIGHT_W-1:0] weight;
        logic [HALF_W-1:0]   a_nxt;
        logic [HALF_W-1:0]   b_nxt;
    } stage_res_t;

    function automatic logic [HALF_W-1:0] prefix_xor(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] r;
        r    = v;
        r[0] = v[0];
        for (int i = 1; i < HALF_W; i++)
        begin
            r[i] = r[i-1] ^ v[i];
        end
        return r;
    endfunction

    function automatic logic [HALF_W-1:0] lin_map(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] r;
        r = '0;
        for (int k = 0; k < HALF_W; k++)
        begin
            if (v[k])
            begin
                r = r ^ PAR_COL[k];
            end
        end
        return r;
    endfunction

    function automatic logic [WEIGHT_W-1:0] ones16(input logic [HALF_W-1:0] v);
        logic [WEIGHT_W-1:0] c;
        c = '0;
        for (int k = 0; k < HALF_W; k++)
        begin
            c = c + WEIGHT_W'(v[k]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/acpe_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface acpe_seed_if;
    import acpe_pkg::*;

    logic              valid;
    logic              ready;
    logic [SEED_W-1:0] seed_state;

    modport source (output valid, output seed_state, input ready);
    modport sink   (input valid, input seed_state, output ready);
endinterface

interface acpe_stage_if;
    import acpe_pkg::*;

    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  stage_index;
    logic [HALF_W-1:0]   stage_word;
    logic [WEIGHT_W-1:0] stage_weight;
    logic                last_stage;

    modport source (output valid, output stage_index, output stage_word,
                    output stage_weight, output last_stage, input ready);
    modport sink   (input valid, input stage_index, input stage_word,
                    input stage_weight, input last_stage, output ready);
endinterface

`default_nettype wire

/* rtl/core/accumulate_parity_chain_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// a taken seed is loaded into a/b, then each stage result is registered at the output,
// one item per cycle unless the output stalls, all through the single shared stage unit
// the next seed is taken in the cycle after the last stage item is registered
// output stalls hold the chain; reset clears the sequencer and the output valid

module accumulate_parity_chain_encoder #(
    parameter int STAGE_COUNT = acpe_pkg::STAGE_COUNT_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    acpe_seed_if.sink     seed_in,
    acpe_stage_if.source  stage_out
);
    import acpe_pkg::*;

    localparam int CNT_W = ($clog2(STAGE_COUNT) > INDEX_W) ? $clog2(STAGE_COUNT) : INDEX_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(STAGE_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [HALF_W-1:0]   a_reg, a_next;
    logic [HALF_W-1:0]   b_reg, b_next;
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    logic [HALF_W-1:0]   out_word_reg, out_word_next;
    logic [WEIGHT_W-1:0] out_weight_reg, out_weight_next;
    logic                out_last_reg, out_last_next;

    stage_res_t          res;
    logic                seed_take;
    logic                advance;
    logic                is_last;

    acpe_stage_unit u_stage (
        .a   (a_reg),
        .b   (b_reg),
        .res (res)
    );

    assign seed_in.ready = (state_reg == ST_IDLE);
    assign seed_take     = seed_in.valid && seed_in.ready;
    assign advance       = (state_reg == ST_RUN) && (!out_valid_reg || stage_out.ready);
    assign is_last       = (cnt_reg == LAST_CNT);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_word_next   = out_word_reg;
        out_weight_next = out_weight_reg;
        out_last_next   = out_last_reg;

        if (out_valid_reg && stage_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (seed_take)
                begin
                    a_next     = seed_in.seed_state[HALF_W-1:0];
                    b_next     = seed_in.seed_state[SEED_W-1:HALF_W];
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = cnt_reg[INDEX_W-1:0];
                    out_word_next   = res.word;
                    out_weight_next = res.weight;
                    out_last_next   = is_last;
                    a_next          = res.a_nxt;
                    b_next          = res.b_nxt;
                    cnt_next        = cnt_reg + CNT_W'(1);
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        out_index_reg  <= out_index_next;
        out_word_reg   <= out_word_next;
        out_weight_reg <= out_weight_next;
        out_last_reg   <= out_last_next;
    end

    assign stage_out.valid        = out_valid_reg;
    assign stage_out.stage_index  = out_index_reg;
    assign stage_out.stage_word   = out_word_reg;
    assign stage_out.stage_weight = out_weight_reg;
    assign stage_out.last_stage   = out_last_reg;

`ifndef SYNTH
    a_seed_starts_chain: assert property (@(posedge clk) disable iff (!rst_n)
        seed_take |=> (state_reg == ST_RUN) && (cnt_reg == '0))
        else $error("seed did not start the stage chain at index zero");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_out.valid && stage_out.last_stage) |->
            (stage_out.stage_index == LAST_CNT[INDEX_W-1:0]))
        else $error("last stage flagged at wrong index");

    a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && out_valid_reg && !stage_out.ready) |=>
            $stable(cnt_reg) && $stable(a_reg) && $stable(b_reg))
        else $error("chain advanced while output stalled");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        stage_out.valid |-> (stage_out.stage_weight <= WEIGHT_W'(HALF_W)))
        else $error("stage weight out of range");
`endif

endmodule

`default_nettype wire

/* rtl/core/acpe_stage_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module acpe_stage_unit (
    input  wire logic [acpe_pkg::HALF_W-1:0] a,
    input  wire logic [acpe_pkg::HALF_W-1:0] b,
    output acpe_pkg::stage_res_t             res
);
    import acpe_pkg::*;

    logic [HALF_W-1:0] acc_a;
    logic [HALF_W-1:0] acc_b;
    logic [HALF_W-1:0] acc_aa;
    logic [HALF_W-1:0] q;

    always_comb
    begin
        acc_a      = prefix_xor(a);
        acc_b      = prefix_xor(b);
        acc_aa     = prefix_xor(acc_a);
        q          = acc_aa ^ acc_b;
        res.word   = q;
        res.weight = ones16(q);
        res.a_nxt  = lin_map(acc_a);
        res.b_nxt  = lin_map(acc_aa ^ acc_b);
    end

endmodule

`default_nettype wire

/* dv/tb_accumulate_parity_chain_encoder.sv */
`timescale 1ns / 1ps

module tb_accumulate_parity_chain_encoder;
    import acpe_pkg::*;

    localparam int STAGES = (STAGE_COUNT_DEFAULT < 1) ? 1 :
                            (STAGE_COUNT_DEFAULT > 64) ? 64 : STAGE_COUNT_DEFAULT;
    localparam int RANDOM_SEEDS_PER_MIX = 125;

    typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic [HALF_W-1:0]   word;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } stage_item_t;

    typedef struct packed {
        logic [SEED_W-1:0] seed;
        logic              all_zero;
    } seed_row_t;

    localparam int SEED_ROWS = 16;

    // rows flagged all_zero expect word 0 and weight 0 on every stage
    seed_row_t seed_table [SEED_ROWS] = '{
        '{32'h0000_0000, 1'b1},
        '{32'hffff_ffff, 1'b0},
        '{32'h0000_ffff, 1'b0},
        '{32'hffff_0000, 1'b0},
        '{32'h0000_0001, 1'b0},
        '{32'h8000_0000, 1'b0},
        '{32'h0000_8000, 1'b0},
        '{32'h0001_0000, 1'b0},
        '{32'haaaa_5555, 1'b0},
        '{32'h5555_aaaa, 1'b0},
        '{32'h0000_0000, 1'b1},
        '{32'h1234_5678, 1'b0},
        '{32'hfedc_ba98, 1'b0},
        '{32'h7fff_ffff, 1'b0},
        '{32'hffff_fffe, 1'b0},
        '{32'h0000_0000, 1'b1}
    };

    logic clk = 1'b0;
    logic rst_n;

    acpe_seed_if  seed_if ();
    acpe_stage_if stage_if ();

    accumulate_parity_chain_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_in   (seed_if.sink),
        .stage_out (stage_if.source)
    );

    stage_item_t chain_expect [$];
    idle_mode_t  idle_mode = IDLE_NONE;
    int unsigned output_hold_cycles = 0;
    int unsigned seeds_taken = 0;
    int unsigned words_checked = 0;
    int unsigned error_count = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit roll(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int unsigned src_idle_pct();
        case (idle_mode)
            IDLE_SRC:  return 84;
            IDLE_BOTH: return 31;
            default:   return 0;
        endcase
    endfunction

    function automatic int unsigned snk_stall_pct();
        case (idle_mode)
            IDLE_SNK:  return 84;
            IDLE_BOTH: return 31;
            default:   return 0;
        endcase
    endfunction

    function automatic logic [HALF_W-1:0] running_xor(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] r;
        r = v;
        r = r ^ (r << 1);
        r = r ^ (r << 2);
        r = r ^ (r << 4);
        r = r ^ (r << 8);
        return r;
    endfunction

    function automatic logic [HALF_W-1:0] parity_image(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] r;
        r = '0;
        for (int k = 0; k < HALF_W; k++)
        begin
            r = r ^ ({HALF_W{v[k]}} & PAR_COL[k]);
        end
        return r;
    endfunction

    function automatic void queue_chain(input logic [SEED_W-1:0] seed, input logic all_zero);
        logic [HALF_W-1:0] a;
        logic [HALF_W-1:0] b;
        logic [HALF_W-1:0] acc_a;
        logic [HALF_W-1:0] acc_b;
        logic [HALF_W-1:0] acc_aa;
        logic [HALF_W-1:0] q;
        stage_item_t       item;
        a = seed[HALF_W-1:0];
        b = seed[SEED_W-1:HALF_W];
        for (int s = 0; s < STAGES; s++)
        begin
            acc_a  = running_xor(a);
            acc_b  = running_xor(b);
            acc_aa = running_xor(acc_a);
            q      = acc_aa ^ acc_b;
            item.index  = INDEX_W'(s);
            item.word   = all_zero ? '0 : q;
            item.weight = all_zero ? '0 : WEIGHT_W'($countones(q));
            item.last   = (s == STAGES - 1);
            chain_expect.push_back(item);
            a = parity_image(acc_a);
            b = parity_image(acc_aa) ^ parity_image(acc_b);
        end
    endfunction

    function automatic logic [SEED_W-1:0] pick_seed();
        logic [SEED_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            5: r = SEED_W'(1) << $urandom_range(0, SEED_W - 1);
            6: r = $urandom_range(0, 1) ? {16'h0000, r[15:0]} : {r[31:16], 16'h0000};
            7: r = ~(SEED_W'(1) << $urandom_range(0, SEED_W - 1));
            8: r = SEED_W'($urandom_range(0, 15));
            9: r = $urandom_range(0, 1) ? {16'hffff, r[15:0]} : {r[31:16], 16'hffff};
            default: ;
        endcase
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic offer_seed(input logic [SEED_W-1:0] seed, input logic all_zero);
        while (roll(src_idle_pct()))
        begin
            seed_if.valid <= 1'b0;
            @(negedge clk);
        end
        seed_if.valid      <= 1'b1;
        seed_if.seed_state <= seed;
        do
            @(posedge clk);
        while (!seed_if.ready);
        queue_chain(seed, all_zero);
        seeds_taken++;
        @(negedge clk);
    endtask

    task automatic drain_chain();
        seed_if.valid <= 1'b0;
        while (chain_expect.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic flag_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    initial
    begin : sink_drive
        stage_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (output_hold_cycles != 0)
            begin
                stage_if.ready <= 1'b0;
                repeat (output_hold_cycles) @(negedge clk);
                output_hold_cycles = 0;
            end
            stage_if.ready <= rst_n && !roll(snk_stall_pct());
        end
    end

    always @(posedge clk)
    begin
        stage_item_t want;
        if (rst_n && stage_if.valid && stage_if.ready)
        begin
            if (chain_expect.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected stage item, expected none, got index %0d word %h",
                         $time, stage_if.stage_index, stage_if.stage_word);
            end
            else
            begin
                want = chain_expect.pop_front();
                words_checked++;
                flag_field("stage_index", want.index, stage_if.stage_index);
                flag_field("stage_word", want.word, stage_if.stage_word);
                flag_field("stage_weight", want.weight, stage_if.stage_weight);
                flag_field("last_stage", want.last, stage_if.last_stage);
            end
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("accumulate_parity_chain_encoder regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        idle_mode_t mixes [4];
        mixes = '{IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH};
        rst_n              = 1'b0;
        seed_if.valid      = 1'b0;
        seed_if.seed_state = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SEED_ROWS; i++)
        begin
            offer_seed(seed_table[i].seed, seed_table[i].all_zero);
        end
        drain_chain();

        // long output hold so the chain backs up and the seed input stalls
        output_hold_cycles = 240;
        for (int i = 0; i < 5; i++)
        begin
            offer_seed(pick_seed(), 1'b0);
        end
        drain_chain();

        foreach (mixes[m])
        begin
            idle_mode = mixes[m];
            for (int i = 0; i < RANDOM_SEEDS_PER_MIX; i++)
            begin
                offer_seed(pick_seed(), 1'b0);
            end
            drain_chain();
        end
        idle_mode = IDLE_NONE;

        repeat (10) @(posedge clk);
        $display("covered %0d seeds and %0d stage words: edge seeds, zero seeds, a long",
                 seeds_taken, words_checked);
        $display("output hold, and random seeds with no idling, input gaps, output stalls, both");
        if (error_count == 0 && chain_expect.size() == 0)
        begin
            $display("accumulate_parity_chain_encoder regression: pass");
        end
        else
        begin
            $display("accumulate_parity_chain_encoder regression: fail");
        end
        $finish;
    end

endmodule
